/* src/nspf_pkg.sv */
// ----------------------------------------------------------------------------
// nspf_pkg
// shared constants, codes and types of the nearest site pressure force block
// ----------------------------------------------------------------------------
package nspf_pkg;

    // site table size
    localparam int MAX_SITES = 1024;
    localparam int IDX_W     = $clog2(MAX_SITES);
    localparam int CNT_W     = IDX_W + 1;
    localparam int OUT_IDX_W = 10;

    // action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_VOXEL  = 3'd0;
    localparam logic [2:0] CFG_ORG_X  = 3'd1;
    localparam logic [2:0] CFG_ORG_Y  = 3'd2;
    localparam logic [2:0] CFG_ORG_Z  = 3'd3;
    localparam logic [2:0] CFG_OFFSET = 3'd4;

    // number of square root steps (one result bit, two radicand bits per step)
    localparam int SQRT_STEPS = 32;
    localparam int SQC_W      = $clog2(SQRT_STEPS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_MUL,
        S_LOAD_WR,
        S_SCAN,
        S_DRAIN,
        S_FMUL,
        S_FSCALE,
        S_FSQ,
        S_SQINIT,
        S_SQRT,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       capture;
        logic       set_status;
        logic [1:0] status;
        logic       clear;
        logic       load_mul;
        logic       load_wr;
        logic       scan_start;
        logic       scan_issue;
        logic       fmul;
        logic       fscale;
        logic       fsq;
        logic       sq_init;
        logic       sq_step;
        logic       out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic scan_last;
        logic pipe_busy;
        logic sqrt_last;
        logic out_free;
    } t_dp_stat;

endpackage

/* src/nspf_ctrl.sv */
// ----------------------------------------------------------------------------
// nspf_ctrl
// sequencer for clear, load and query words
// ----------------------------------------------------------------------------
module nspf_ctrl
    import nspf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DONE;
                    unique case (i_action)
                        ACT_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        ACT_LOAD: begin
                            if (i_stat.count_full) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = STS_FULL;
                            end else begin
                                n_state = S_LOAD_MUL;
                            end
                        end
                        ACT_QUERY: begin
                            if (i_stat.count_zero) begin
                                o_cmd.set_status = 1'b1;
                                o_cmd.status     = STS_EMPTY;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD_MUL: begin
                o_cmd.load_mul = 1'b1;
                n_state        = S_LOAD_WR;
            end
            S_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_FMUL;
                end
            end
            S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = S_FSCALE;
            end
            S_FSCALE: begin
                o_cmd.fscale = 1'b1;
                n_state      = S_FSQ;
            end
            S_FSQ: begin
                o_cmd.fsq = 1'b1;
                n_state   = S_SQINIT;
            end
            S_SQINIT: begin
                o_cmd.sq_init = 1'b1;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sq_step = 1'b1;
                if (i_stat.sqrt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/nspf_dp.sv */
// ----------------------------------------------------------------------------
// nspf_dp
// site memory, configuration, scan pipeline, force and magnitude units
// ----------------------------------------------------------------------------
module nspf_dp
    import nspf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [15:0]          i_coord_x,
    input  logic [15:0]          i_coord_y,
    input  logic [15:0]          i_coord_z,
    input  logic signed [31:0]   i_press_x,
    input  logic signed [31:0]   i_press_y,
    input  logic signed [31:0]   i_press_z,
    input  logic signed [31:0]   i_query_x,
    input  logic signed [31:0]   i_query_y,
    input  logic signed [31:0]   i_query_z,
    input  logic [31:0]          i_cell_area,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic signed [31:0]   o_force_x,
    output logic signed [31:0]   o_force_y,
    output logic signed [31:0]   o_force_z,
    output logic [31:0]          o_force_magnitude,
    output logic [OUT_IDX_W-1:0] o_nearest_index,
    output logic [1:0]           o_status
);

    // configuration registers
    logic [31:0]        r_voxel;
    logic signed [31:0] r_org_x, r_org_y, r_org_z, r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voxel  <= 32'd65536;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_z  <= '0;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VOXEL:  r_voxel  <= i_cfg_data;
                CFG_ORG_X:  r_org_x  <= i_cfg_data;
                CFG_ORG_Y:  r_org_y  <= i_cfg_data;
                CFG_ORG_Z:  r_org_z  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured input word
    logic [15:0]        r_cx, r_cy, r_cz;
    logic signed [31:0] r_px, r_py, r_pz, r_qx, r_qy, r_qz;
    logic [31:0]        r_area;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cx   <= i_coord_x;
            r_cy   <= i_coord_y;
            r_cz   <= i_coord_z;
            r_px   <= i_press_x;
            r_py   <= i_press_y;
            r_pz   <= i_press_z;
            r_qx   <= i_query_x;
            r_qy   <= i_query_y;
            r_qz   <= i_query_z;
            r_area <= i_cell_area;
        end
    end

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // load: products first, then add and saturate
    logic [47:0] r_mx, r_my, r_mz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_mx <= r_voxel * r_cx;
            r_my <= r_voxel * r_cy;
            r_mz <= r_voxel * r_cz;
        end
    end

    logic [191:0] w_wr_row;

    always_comb begin
        w_wr_row[31:0]    = sat50(50'(r_org_x) + $signed({2'b00, r_mx}));
        w_wr_row[63:32]   = sat50(50'(r_org_y) + $signed({2'b00, r_my}));
        w_wr_row[95:64]   = sat50(50'(r_org_z) + $signed({2'b00, r_mz}));
        w_wr_row[127:96]  = sat50(50'(r_px) + 50'(r_offset));
        w_wr_row[159:128] = sat50(50'(r_py) + 50'(r_offset));
        w_wr_row[191:160] = sat50(50'(r_pz) + 50'(r_offset));
    end

    // site count
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.load_wr) begin
            r_count <= r_count + 1'b1;
        end
    end

    // site memory: one row per site, position then pressure
    logic [191:0]     r_mem [MAX_SITES];
    logic [191:0]     r_rd_row;
    logic [IDX_W-1:0] r_scan_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            r_mem[r_count[IDX_W-1:0]] <= w_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_row <= r_mem[r_scan_idx];
    end

    // scan address and pipeline valids
    logic             r_rd_v, r_sq_v, r_first;
    logic [IDX_W-1:0] r_rd_idx, r_sq_idx, r_best_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_sq_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.scan_issue;
            r_sq_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        r_rd_idx <= r_scan_idx;
        r_sq_idx <= r_rd_idx;
    end

    // squared distance per axis
    function automatic logic [63:0] sq_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [31:0]        m;
        d = 33'(a) - 33'(b);
        m = d[32] ? 32'(-d) : d[31:0];
        return m * m;
    endfunction

    logic [63:0]  r_sqx, r_sqy, r_sqz;
    logic [95:0]  r_sq_press;

    always_ff @(posedge i_clk) begin
        r_sqx      <= sq_diff(r_qx, r_rd_row[31:0]);
        r_sqy      <= sq_diff(r_qy, r_rd_row[63:32]);
        r_sqz      <= sq_diff(r_qz, r_rd_row[95:64]);
        r_sq_press <= r_rd_row[191:96];
    end

    // running minimum, first site wins a tie
    logic [65:0] w_dist, r_best_dist;
    logic [95:0] r_best_press;

    assign w_dist = 66'(r_sqx) + 66'(r_sqy) + 66'(r_sqz);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_first <= 1'b1;
        end else if (r_sq_v && (r_first || w_dist < r_best_dist)) begin
            r_first      <= 1'b0;
            r_best_dist  <= w_dist;
            r_best_idx   <= r_sq_idx;
            r_best_press <= r_sq_press;
        end
    end

    // force: magnitude product, then floor shift and saturate
    logic [63:0] r_fp_x, r_fp_y, r_fp_z;
    logic [2:0]  r_fneg;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return w[32] ? 32'(-w) : w[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.fmul) begin
            r_fp_x <= abs32(r_best_press[31:0]) * r_area;
            r_fp_y <= abs32(r_best_press[63:32]) * r_area;
            r_fp_z <= abs32(r_best_press[95:64]) * r_area;
            r_fneg <= {r_best_press[95], r_best_press[63], r_best_press[31]};
        end
    end

    function automatic logic signed [31:0] scale(input logic [63:0] prod, input logic neg);
        logic [47:0] q;
        if (neg) begin
            q = 48'((prod + 64'hffff) >> 16);
            if (q > 48'd2147483648) begin
                return 32'sh80000000;
            end
            return 32'(-q);
        end
        q = 48'(prod >> 16);
        if (q > 48'd2147483647) begin
            return 32'sh7fffffff;
        end
        return q[31:0];
    endfunction

    logic signed [31:0] r_fx, r_fy, r_fz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_fx <= '0;
            r_fy <= '0;
            r_fz <= '0;
        end else if (i_cmd.fscale) begin
            r_fx <= scale(r_fp_x, r_fneg[0]);
            r_fy <= scale(r_fp_y, r_fneg[1]);
            r_fz <= scale(r_fp_z, r_fneg[2]);
        end
    end

    // squares of force components
    logic [63:0] r_fsx, r_fsy, r_fsz;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fsq) begin
            r_fsx <= abs32(r_fx) * abs32(r_fx);
            r_fsy <= abs32(r_fy) * abs32(r_fy);
            r_fsz <= abs32(r_fz) * abs32(r_fz);
        end
    end

    // bitwise square root, one result bit per step
    logic [63:0]      r_rem, r_root, r_bit, w_trial;
    logic [SQC_W-1:0] r_sq_cnt;

    assign w_trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_root <= '0;
        end else if (i_cmd.sq_init) begin
            r_rem    <= r_fsx + r_fsy + r_fsz;
            r_root   <= '0;
            r_bit    <= 64'h4000_0000_0000_0000;
            r_sq_cnt <= '0;
        end else if (i_cmd.sq_step) begin
            if (r_rem >= w_trial) begin
                r_rem  <= r_rem - w_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit    <= r_bit >> 2;
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end
    end

    // result status and index
    logic [1:0]       r_res_status;
    logic             r_res_query;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) begin
            r_res_status <= i_cmd.status;
        end else if (i_cmd.capture) begin
            r_res_status <= STS_OK;
        end
        if (i_cmd.scan_start) begin
            r_res_query <= 1'b1;
        end else if (i_cmd.capture) begin
            r_res_query <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_force_x         <= r_fx;
            o_force_y         <= r_fy;
            o_force_z         <= r_fz;
            o_force_magnitude <= r_root[31:0];
            o_nearest_index   <= r_res_query ? OUT_IDX_W'(r_best_idx) : '0;
            o_status          <= r_res_status;
        end
    end

    // status to controller
    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.count_full = (r_count >= CNT_W'(MAX_SITES));
        o_stat.scan_last  = ({1'b0, r_scan_idx} == r_count - 1'b1);
        o_stat.pipe_busy  = r_rd_v | r_sq_v;
        o_stat.sqrt_last  = (r_sq_cnt == SQC_W'(SQRT_STEPS - 1));
        o_stat.out_free   = !o_out_valid || !i_out_stall;
    end

endmodule

/* src/nearest_site_pressure_force_top.sv */
// ----------------------------------------------------------------------------
// nearest_site_pressure_force_top
// nearest site search over a loaded table, returns scaled pressure force
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  input     in         i_in_valid / o_in_stall    action, coords, pressures, query, area
//  output    out        o_out_valid / i_out_stall  force x/y/z, magnitude, index, status
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  clear and unused actions go straight to the done state, a load passes a
//  multiply and a write state, a query reads one site per cycle from the
//  site memory port, then runs the force multiply and a 32 step square root.
//  one word is in work at a time; the output register lets a new word enter
//  while a result waits. reset is synchronous and empties the table.
// ----------------------------------------------------------------------------
module nearest_site_pressure_force_top
    import nspf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_action,
    input  logic [15:0]          i_coord_x,
    input  logic [15:0]          i_coord_y,
    input  logic [15:0]          i_coord_z,
    input  logic signed [31:0]   i_press_x,
    input  logic signed [31:0]   i_press_y,
    input  logic signed [31:0]   i_press_z,
    input  logic signed [31:0]   i_query_x,
    input  logic signed [31:0]   i_query_y,
    input  logic signed [31:0]   i_query_z,
    input  logic [31:0]          i_cell_area,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_force_x,
    output logic signed [31:0]   o_force_y,
    output logic signed [31:0]   o_force_z,
    output logic [31:0]          o_force_magnitude,
    output logic [OUT_IDX_W-1:0] o_nearest_index,
    output logic [1:0]           o_status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer
    nspf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath
    nspf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .i_press_x         (i_press_x),
        .i_press_y         (i_press_y),
        .i_press_z         (i_press_z),
        .i_query_x         (i_query_x),
        .i_query_y         (i_query_y),
        .i_query_z         (i_query_z),
        .i_cell_area       (i_cell_area),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_force_x         (o_force_x),
        .o_force_y         (o_force_y),
        .o_force_z         (o_force_z),
        .o_force_magnitude (o_force_magnitude),
        .o_nearest_index   (o_nearest_index),
        .o_status          (o_status)
    );

endmodule
